### rtl/ddpi_pkg.sv
package ddpi_pkg;

	// CORDIC datapath: x and y in Q2.30 with guard bits, angle in Q2.30 radians.
	localparam int CORDIC_STEPS = 24;
	localparam int STEP_W = 5;
	localparam int CW = 40;
	localparam int ZW = 36;

	localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [CW-1:0] GAIN_Q30 = 40'sd652032874;

	// Heading constants in Q3.16 radians.
	localparam int PI_Q16 = 205887;
	localparam int TWO_PI_Q16 = 411775;

	// Configuration register indexes.
	localparam logic [2:0] REG_POSE_SOURCE = 3'd0;
	localparam logic [2:0] REG_TICK_SECONDS = 3'd1;
	localparam logic [2:0] REG_START_X = 3'd2;
	localparam logic [2:0] REG_START_Y = 3'd3;
	localparam logic [2:0] REG_START_HEADING = 3'd4;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_VDT,
		ST_WDT,
		ST_WSTEP,
		ST_ROT,
		ST_MULC,
		ST_MULS,
		ST_ADDY,
		ST_Q0,
		ST_Q1,
		ST_Q2,
		ST_Q3,
		ST_Q4,
		ST_QVEC,
		ST_QRUN,
		ST_WRAP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic vectoring;
	} cordic_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cordic_sts_t;

	function automatic logic signed [ZW-1:0] atan_q30(input logic [STEP_W-1:0] idx);
		logic signed [ZW-1:0] a;
		case (idx)
			5'd0: a = 36'sh03243F6A8;
			5'd1: a = 36'sh01DAC6705;
			5'd2: a = 36'sh00FADBAFC;
			5'd3: a = 36'sh007F56EA6;
			5'd4: a = 36'sh003FEAB76;
			5'd5: a = 36'sh001FFD55B;
			5'd6: a = 36'sh000FFFAAA;
			5'd7: a = 36'sh0007FFF55;
			5'd8: a = 36'sh0003FFFEA;
			5'd9: a = 36'sh0001FFFFD;
			5'd10: a = 36'sh0000FFFFF;
			5'd11: a = 36'sh00007FFFF;
			5'd12: a = 36'sh00003FFFF;
			5'd13: a = 36'sh00001FFFF;
			5'd14: a = 36'sh00000FFFF;
			5'd15: a = 36'sh000007FFF;
			5'd16: a = 36'sh000003FFF;
			5'd17: a = 36'sh000001FFF;
			5'd18: a = 36'sh000000FFF;
			5'd19: a = 36'sh0000007FF;
			5'd20: a = 36'sh0000003FF;
			5'd21: a = 36'sh0000001FF;
			5'd22: a = 36'sh0000000FF;
			5'd23: a = 36'sh00000007F;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

### rtl/ddpi_cordic.sv
module ddpi_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ddpi_pkg::cordic_cmd_t             cmd,
	input  logic signed [ddpi_pkg::CW-1:0]    x0,
	input  logic signed [ddpi_pkg::CW-1:0]    y0,
	input  logic signed [ddpi_pkg::ZW-1:0]    z0,
	output ddpi_pkg::cordic_sts_t             sts,
	output logic signed [ddpi_pkg::CW-1:0]    x,
	output logic signed [ddpi_pkg::CW-1:0]    y,
	output logic signed [ddpi_pkg::ZW-1:0]    z
);
	import ddpi_pkg::*;

	logic                 running_q;
	logic                 done_q;
	logic [STEP_W-1:0]    step_q;
	logic                 vec_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;

	logic                 last;
	logic                 ccw;
	logic signed [CW-1:0] dx, dy;
	logic signed [ZW-1:0] ang;

	assign last = (step_q == STEP_W'(CORDIC_STEPS - 1));

	// Rotation mode drives the angle to zero, vectoring mode drives y to zero.
	always_comb begin
		dx = y_q >>> step_q;
		dy = x_q >>> step_q;
		ang = atan_q30(step_q);
		ccw = vec_q ? y_q[CW-1] : !z_q[ZW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= running_q && last;
			if (cmd.start) begin
				running_q <= 1'b1;
				step_q <= '0;
			end else if (running_q) begin
				step_q <= step_q + 1'b1;
				if (last) begin
					running_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
			vec_q <= cmd.vectoring;
		end else if (running_q) begin
			if (ccw) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end
		end
	end

	assign sts.busy = running_q;
	assign sts.done = done_q;
	assign x = x_q;
	assign y = y_q;
	assign z = z_q;

endmodule

### rtl/diff_drive_pose_integrator_core.sv
// A new tick is taken only once the last one's pose has moved to the output register, in
// either mode; in pose mode a zero quaternion sine term skips the CORDIC. The CORDIC and
// the heading wrap run on shared units, and a new tick is taken while the last pose waits
// downstream.
// Reset: pose is cleared, pose_source is 0 and tick_seconds is 2621; start writes load the pose.
module diff_drive_pose_integrator_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [2:0]   cfg_idx,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// lin_vel[23:0], ang_vel[47:24], odo_x[79:48], odo_y[111:80],
	// quat_w[127:112], quat_x[143:128], quat_y[159:144], quat_z[175:160]
	input  logic [175:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pose_x[31:0], pose_y[63:32], heading[82:64], zero[87:83]
	output logic [87:0]  m_tdata
);
	import ddpi_pkg::*;

	localparam logic signed [26:0] WRAP_OFS = 27'(TWO_PI_Q16 * 64);

	state_t state_q, state_d;

	logic                pose_source_q;
	logic [16:0]         dt_q;
	logic [31:0]         pos_x_q, pos_y_q;
	logic signed [18:0]  yaw_q;

	logic signed [23:0]  v_q, w_q;
	logic signed [15:0]  qw_q, qx_q, qy_q, qz_q;

	logic signed [40:0]  mul_a;
	logic signed [18:0]  mul_b;
	logic signed [59:0]  prod_q;
	logic signed [40:0]  vdt_q;
	logic signed [31:0]  pq_q;
	logic signed [33:0]  sn_q, cs_q;
	logic signed [26:0]  r_q;
	logic [2:0]          wcnt_q;
	logic                flip_q;

	logic                out_valid_q;
	logic [31:0]         out_x_q, out_y_q;
	logic signed [18:0]  out_h_q;

	cordic_cmd_t          cmd;
	cordic_sts_t          sts;
	logic signed [CW-1:0] x0, y0, cx, cy;
	logic signed [ZW-1:0] z0, cz;

	logic                 accept;
	logic                 out_free;
	logic signed [CW-1:0] cx_f, cy_f, cx_r, cy_r;
	logic signed [18:0]   cos_v, sin_v;
	logic signed [59:0]   wsum, psum;
	logic signed [26:0]   wstep;
	logic [31:0]          pstep;
	logic signed [32:0]   qsum;
	logic signed [ZW-1:0] hz, czr;
	logic signed [26:0]   zstep;
	logic signed [26:0]   wmod;
	logic signed [18:0]   yaw_new;
	logic                 cs_neg;

	function automatic logic signed [18:0] wrap_start(input logic signed [18:0] h);
		logic signed [20:0] r;
		r = 21'(h) + 21'(PI_Q16);
		if (r < 0) begin
			r = r + 21'(TWO_PI_Q16);
		end else if (r >= 21'(TWO_PI_Q16)) begin
			r = r - 21'(TWO_PI_Q16);
		end
		return 19'(r - 21'(PI_Q16));
	endfunction

	ddpi_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.x0     (x0),
		.y0     (y0),
		.z0     (z0),
		.sts    (sts),
		.x      (cx),
		.y      (cy),
		.z      (cz)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = {5'b0, out_h_q, out_y_q, out_x_q};

	// Rounding and fixed-point alignment of the shared results.
	always_comb begin
		cx_f = flip_q ? -cx : cx;
		cy_f = flip_q ? -cy : cy;
		cx_r = cx_f + 40'sd8192;
		cy_r = cy_f + 40'sd8192;
		cos_v = cx_r[32:14];
		sin_v = cy_r[32:14];
		wsum = prod_q + 60'sd32768;
		wstep = wsum[42:16];
		psum = prod_q + 60'sd2147483648;
		pstep = {{4{psum[59]}}, psum[59:32]};
		qsum = 33'(pq_q) + 33'($signed(prod_q[31:0]));
		hz = {{3{yaw_q[18]}}, yaw_q, 14'b0};
		czr = cz + 36'sd8192;
		zstep = 27'($signed(czr[ZW-1:14]));
		wmod = WRAP_OFS >>> (wcnt_q - 3'd1);
		yaw_new = 19'(r_q - 27'(PI_Q16));
		cs_neg = cs_q[33];
	end

	// Shared multiplier operands.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_VDT: begin
				mul_a = 41'(v_q);
				mul_b = {2'b00, dt_q};
			end
			ST_WDT: begin
				mul_a = 41'(w_q);
				mul_b = {2'b00, dt_q};
			end
			ST_MULC: begin
				mul_a = vdt_q;
				mul_b = cos_v;
			end
			ST_MULS: begin
				mul_a = vdt_q;
				mul_b = sin_v;
			end
			ST_Q0: begin
				mul_a = 41'(qw_q);
				mul_b = 19'(qz_q);
			end
			ST_Q1: begin
				mul_a = 41'(qx_q);
				mul_b = 19'(qy_q);
			end
			ST_Q2: begin
				mul_a = 41'(qy_q);
				mul_b = 19'(qy_q);
			end
			ST_Q3: begin
				mul_a = 41'(qz_q);
				mul_b = 19'(qz_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.start = 1'b0;
		cmd.vectoring = 1'b0;
		x0 = GAIN_Q30;
		y0 = '0;
		z0 = hz;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = pose_source_q ? ST_Q0 : ST_VDT;
				end
			end
			ST_VDT: state_d = ST_WDT;
			ST_WDT: state_d = ST_WSTEP;
			ST_WSTEP: begin
				// Fold the heading into [-pi/2, pi/2] and negate the result afterwards.
				cmd.start = 1'b1;
				if (hz > HALF_PI_Q30) begin
					z0 = hz - PI_Q30;
				end else if (hz < -HALF_PI_Q30) begin
					z0 = hz + PI_Q30;
				end
				state_d = ST_ROT;
			end
			ST_ROT: begin
				if (sts.done) begin
					state_d = ST_MULC;
				end
			end
			ST_MULC: state_d = ST_MULS;
			ST_MULS: state_d = ST_ADDY;
			ST_ADDY: state_d = ST_WRAP;
			ST_Q0: state_d = ST_Q1;
			ST_Q1: state_d = ST_Q2;
			ST_Q2: state_d = ST_Q3;
			ST_Q3: state_d = ST_Q4;
			ST_Q4: state_d = ST_QVEC;
			ST_QVEC: begin
				if (sn_q == '0) begin
					state_d = ST_WRAP;
				end else begin
					// A negative cosine term starts from the opposite half plane.
					cmd.start = 1'b1;
					cmd.vectoring = 1'b1;
					x0 = cs_neg ? -CW'(cs_q) : CW'(cs_q);
					y0 = cs_neg ? -CW'(sn_q) : CW'(sn_q);
					z0 = cs_neg ? (sn_q[33] ? -PI_Q30 : PI_Q30) : '0;
					state_d = ST_QRUN;
				end
			end
			ST_QRUN: begin
				if (sts.done) begin
					state_d = ST_WRAP;
				end
			end
			ST_WRAP: begin
				if (wcnt_q == 3'd7) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Architectural state: configuration and pose.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_source_q <= 1'b0;
			dt_q <= 17'd2621;
			pos_x_q <= '0;
			pos_y_q <= '0;
			yaw_q <= '0;
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					REG_POSE_SOURCE: pose_source_q <= cfg_wdata[0];
					REG_TICK_SECONDS: dt_q <= cfg_wdata[16:0];
					REG_START_X: pos_x_q <= cfg_wdata;
					REG_START_Y: pos_y_q <= cfg_wdata;
					REG_START_HEADING: yaw_q <= wrap_start(cfg_wdata[18:0]);
					default: ;
				endcase
			end
			if (accept && pose_source_q) begin
				pos_x_q <= s_tdata[79:48];
				pos_y_q <= s_tdata[111:80];
			end
			if (state_q == ST_MULS) begin
				pos_x_q <= pos_x_q + pstep;
			end
			if (state_q == ST_ADDY) begin
				pos_y_q <= pos_y_q + pstep;
			end
			if (state_q == ST_DONE && out_free) begin
				yaw_q <= yaw_new;
			end
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			v_q <= s_tdata[23:0];
			w_q <= s_tdata[47:24];
			qw_q <= s_tdata[127:112];
			qx_q <= s_tdata[143:128];
			qy_q <= s_tdata[159:144];
			qz_q <= s_tdata[175:160];
		end
		if (state_q == ST_WRAP) begin
			wcnt_q <= wcnt_q + 1'b1;
		end else begin
			wcnt_q <= '0;
		end
		case (state_q)
			ST_WDT: vdt_q <= prod_q[40:0];
			ST_WSTEP: begin
				r_q <= 27'(yaw_q) + wstep + 27'(PI_Q16);
				flip_q <= (hz > HALF_PI_Q30) || (hz < -HALF_PI_Q30);
			end
			ST_Q1: pq_q <= prod_q[31:0];
			ST_Q2: sn_q <= {qsum, 1'b0};
			ST_Q3: pq_q <= prod_q[31:0];
			ST_Q4: cs_q <= 34'sd1073741824 - {qsum, 1'b0};
			ST_QVEC: begin
				flip_q <= 1'b0;
				if (sn_q == '0) begin
					r_q <= cs_neg ? 27'(2 * PI_Q16) : 27'(PI_Q16);
				end
			end
			ST_QRUN: begin
				if (sts.done) begin
					r_q <= zstep + 27'(PI_Q16);
				end
			end
			ST_WRAP: begin
				// First bring the value above zero, then strip multiples of 2*pi from the
				// largest power-of-two multiple down.
				if (wcnt_q == 3'd0) begin
					if (r_q < 0) begin
						r_q <= r_q + WRAP_OFS;
					end
				end else if (r_q >= wmod) begin
					r_q <= r_q - wmod;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_x_q <= pos_x_q;
			out_y_q <= pos_y_q;
			out_h_q <= yaw_new;
		end
	end

`ifndef ASSERT_OFF
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after accepting a tick");

	a_yaw_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(yaw_q >= -19'(PI_Q16)) && (yaw_q <= 19'(PI_Q16)))
		else $error("held heading outside [-pi, pi]");

	a_cordic_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> (state_q == ST_ROT || state_q == ST_QRUN))
		else $error("CORDIC finished while the sequencer was not waiting on it");

	a_idle_cordic_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !sts.busy)
		else $error("CORDIC still running while ready for a new tick");
`endif

endmodule

### test/diff_drive_pose_integrator_core_test.sv
`timescale 1ns / 100ps

module diff_drive_pose_integrator_core_test;
	import ddpi_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 60;
	localparam int REPORT_LIMIT = 10;

	// One tick as it travels on s_tdata, the last field listed in the lowest bits.
	typedef struct packed {
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_w;
		logic signed [31:0] odo_y;
		logic signed [31:0] odo_x;
		logic signed [23:0] ang_vel;
		logic signed [23:0] lin_vel;
	} tick_t;

	// One pose as it travels on m_tdata.
	typedef struct packed {
		logic [4:0]         pad;
		logic signed [18:0] heading;
		logic [31:0]        y;
		logic [31:0]        x;
	} pose_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wen = 1'b0;
	logic [2:0]   cfg_idx = '0;
	logic [31:0]  cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [175:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [87:0]  m_tdata;

	// Pose tracker state, kept in step with the block.
	bit          src_pose = 1'b0;
	logic [16:0] step_dt = 17'd2621;
	logic [31:0] cur_x = '0;
	logic [31:0] cur_y = '0;
	longint      cur_yaw = 0;

	longint atan_tab [0:23] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	pose_t       expected_poses [$];
	int          mismatches = 0;
	int unsigned cycle_count;
	int          tx_burst_left = 0;
	bit          tx_gaps_on = 1'b1;
	int          rx_hold_request = 0;
	int          rx_hold_left = 0;
	int unsigned rx_cycle = 0;

	diff_drive_pose_integrator_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint round_half_up(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint wrap_heading(input longint h);
		longint r;
		r = (h + PI_Q16) % TWO_PI_Q16;
		if (r < 0)
			r += TWO_PI_Q16;
		return r - PI_Q16;
	endfunction

	// Rotation-mode CORDIC; the heading is folded into the right half plane first.
	function automatic void heading_cos_sin(input longint h, output longint c, output longint s);
		longint x, y, z, dx, dy;
		bit flip;
		int i;
		z = h * 16384;
		x = longint'(GAIN_Q30);
		y = 0;
		flip = 1'b0;
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			flip = 1'b1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30;
			flip = 1'b1;
		end
		for (i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_tab[i];
			end else begin
				x += dx;
				y -= dy;
				z += atan_tab[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = round_half_up(x, 14);
		s = round_half_up(y, 14);
	endfunction

	// Vectoring-mode CORDIC; a zero sine term bypasses the iterations.
	function automatic longint cordic_atan2(input longint sn, input longint cs);
		longint x, y, z, dx, dy;
		int i;
		if (sn == 0)
			return (cs >= 0) ? longint'(0) : longint'(PI_Q16);
		x = cs;
		y = sn;
		z = 0;
		if (cs < 0) begin
			z = (sn >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
			x = -cs;
			y = -sn;
		end
		for (i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += atan_tab[i];
			end else begin
				x -= dx;
				y += dy;
				z -= atan_tab[i];
			end
		end
		return wrap_heading(round_half_up(z, 14));
	endfunction

	function automatic pose_t advance_pose(input tick_t t);
		pose_t p;
		longint v, w, dtl, c, s, dx, dy;
		longint qw, qx, qy, qz, sn, cs;
		if (src_pose) begin
			qw = longint'(t.quat_w);
			qx = longint'(t.quat_x);
			qy = longint'(t.quat_y);
			qz = longint'(t.quat_z);
			sn = 2 * (qw * qz + qx * qy);
			cs = (longint'(1) << 30) - 2 * (qy * qy + qz * qz);
			cur_x = t.odo_x;
			cur_y = t.odo_y;
			cur_yaw = cordic_atan2(sn, cs);
		end else begin
			v = longint'(t.lin_vel);
			w = longint'(t.ang_vel);
			dtl = longint'(step_dt);
			heading_cos_sin(cur_yaw, c, s);
			dx = round_half_up(v * dtl * c, 32);
			dy = round_half_up(v * dtl * s, 32);
			cur_x = cur_x + dx[31:0];
			cur_y = cur_y + dy[31:0];
			cur_yaw = wrap_heading(cur_yaw + round_half_up(w * dtl, 16));
		end
		p.pad = '0;
		p.x = cur_x;
		p.y = cur_y;
		p.heading = cur_yaw[18:0];
		return p;
	endfunction

	function automatic tick_t vel_tick(input int v, input int w);
		tick_t t;
		t = '0;
		t.lin_vel = 24'(v);
		t.ang_vel = 24'(w);
		return t;
	endfunction

	function automatic tick_t quat_tick(input logic [31:0] ox, input logic [31:0] oy,
			input int qw, input int qx, input int qy, input int qz);
		tick_t t;
		t.lin_vel = 24'h7FFFFF;
		t.ang_vel = 24'h800000;
		t.odo_x = ox;
		t.odo_y = oy;
		t.quat_w = 16'(qw);
		t.quat_x = 16'(qx);
		t.quat_y = 16'(qy);
		t.quat_z = 16'(qz);
		return t;
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		logic signed [23:0] v, w;
		v = 24'($urandom);
		w = 24'($urandom);
		t.lin_vel = v >>> $urandom_range(0, 16);
		t.ang_vel = w >>> $urandom_range(0, 16);
		t.odo_x = $urandom;
		t.odo_y = $urandom;
		t.quat_w = 16'($urandom);
		t.quat_x = 16'($urandom);
		t.quat_y = 16'($urandom);
		t.quat_z = 16'($urandom);
		// Now and then make the sine term of the yaw formula vanish.
		if ($urandom_range(0, 7) == 0) begin
			if ($urandom_range(0, 1) == 1)
				t.quat_w = '0;
			else
				t.quat_z = '0;
			if ($urandom_range(0, 1) == 1)
				t.quat_x = '0;
			else
				t.quat_y = '0;
		end
		return t;
	endfunction

	task automatic send_tick(input tick_t t);
		int gap;
		gap = 0;
		if (tx_gaps_on && tx_burst_left == 0) begin
			tx_burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 40);
		end
		if (tx_burst_left > 0)
			tx_burst_left--;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= t;
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		expected_poses.push_back(advance_pose(t));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_poses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_POSE_SOURCE: src_pose = data[0];
			REG_TICK_SECONDS: step_dt = data[16:0];
			REG_START_X: cur_x = data;
			REG_START_Y: cur_y = data;
			REG_START_HEADING: cur_yaw = wrap_heading(longint'($signed(data[18:0])));
			default: ;
		endcase
	endtask

	task automatic load_setup(input bit src, input int dt, input logic [31:0] sx,
			input logic [31:0] sy, input int sh);
		wait_idle();
		write_reg(REG_POSE_SOURCE, {31'b0, src});
		write_reg(REG_TICK_SECONDS, dt);
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_START_HEADING, sh);
	endtask

	// Runs on the values left by reset.
	task automatic test_velocity_extremes();
		send_tick(vel_tick(0, 0));
		send_tick(vel_tick(8388607, 0));
		send_tick(vel_tick(-8388608, 0));
		send_tick(vel_tick(0, 8388607));
		send_tick(vel_tick(0, -8388608));
		send_tick(vel_tick(8388607, 8388607));
		send_tick(vel_tick(-8388608, -8388608));
	endtask

	task automatic test_heading_wrap();
		load_setup(1'b0, 65536, 32'd0, 32'd0, PI_Q16);
		send_tick(vel_tick(8388607, 8388607));
		send_tick(vel_tick(8388607, 1));
		load_setup(1'b0, 65536, 32'd0, 32'd0, -PI_Q16);
		send_tick(vel_tick(-8388608, -8388608));
		send_tick(vel_tick(-8388608, -1));
		// Step sizes beyond one second are taken as they are.
		load_setup(1'b0, 131071, 32'd0, 32'd0, 0);
		send_tick(vel_tick(8388607, 8388607));
		send_tick(vel_tick(-8388608, -8388608));
	endtask

	task automatic test_position_wrap();
		load_setup(1'b0, 65536, 32'h7FFFFFFF, 32'h80000000, 0);
		send_tick(vel_tick(8388607, 0));
		send_tick(vel_tick(8388607, 0));
		load_setup(1'b0, 65536, 32'h7FFFFFFF, 32'h80000000, -(PI_Q16 / 2));
		send_tick(vel_tick(8388607, 0));
		send_tick(vel_tick(-8388608, 0));
	endtask

	task automatic test_pose_mode();
		load_setup(1'b1, 2621, 32'd0, 32'd0, 0);
		send_tick(quat_tick(32'h7FFFFFFF, 32'h80000000, 32767, 0, 0, 0));
		send_tick(quat_tick(32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 32767));
		send_tick(quat_tick(32'h00010000, 32'hFFFF0000, 0, 32767, 0, 0));
		send_tick(quat_tick(32'h0, 32'h0, 0, 0, 32767, 0));
		send_tick(quat_tick(32'h0, 32'h0, 0, 0, 0, 0));
		send_tick(quat_tick(32'hFFFFFFFF, 32'h1, -32768, -32768, -32768, -32768));
		send_tick(quat_tick(32'h12345678, 32'h9ABCDEF0, 23170, 0, 0, 23170));
		send_tick(quat_tick(32'h0, 32'h0, 23170, 0, 0, -23170));
	endtask

	task automatic test_zero_step();
		load_setup(1'b0, 0, $urandom, $urandom, -PI_Q16);
		send_tick(vel_tick(8388607, 8388607));
		send_tick(vel_tick(-8388608, -8388608));
	endtask

	// The receiver holds off while ticks keep coming, so the block has to stall its input.
	task automatic test_output_stall();
		int n;
		load_setup(1'b0, 2621, $urandom, $urandom, 0);
		tx_gaps_on = 1'b0;
		rx_hold_request = 400;
		for (n = 0; n < 12; n++)
			send_tick(random_tick());
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_random_ticks();
		int phase, n, dt;
		for (phase = 0; phase < 7; phase++) begin
			case ($urandom_range(0, 5))
				0: dt = 0;
				1: dt = 65536;
				2: dt = 131071;
				3: dt = 2621;
				default: dt = $urandom_range(0, 131071);
			endcase
			load_setup(phase % 3 == 2, dt, $urandom, $urandom,
				int'($urandom_range(0, 2 * PI_Q16)) - PI_Q16);
			for (n = 0; n < 200; n++)
				send_tick(random_tick());
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_velocity_extremes();
		test_heading_wrap();
		test_position_wrap();
		test_pose_mode();
		test_zero_step();
		test_output_stall();
		test_random_ticks();
		wait_idle();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Output side: check each transaction, then pick the next ready value.
	initial begin
		pose_t got, want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
				got = m_tdata;
				if (expected_poses.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("unexpected pose x %h y %h heading %h", got.x, got.y,
							got.heading);
					mismatches++;
				end else begin
					want = expected_poses.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.heading !== want.heading) begin
						if (mismatches < REPORT_LIMIT)
							$display("pose mismatch: x %h/%h y %h/%h heading %h/%h (exp/got)",
								want.x, got.x, want.y, got.y, want.heading, got.heading);
						mismatches++;
					end
				end
			end
			rx_cycle++;
			if (rx_hold_request > 0) begin
				rx_hold_left = rx_hold_request;
				rx_hold_request = 0;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else begin
				case ((rx_cycle / 300) % 4)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= (rx_cycle % 5 == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

endmodule

### filelist.f
rtl/ddpi_pkg.sv
rtl/ddpi_cordic.sv
rtl/diff_drive_pose_integrator_core.sv
test/diff_drive_pose_integrator_core_test.sv
